// ===== src/stok_pkg.sv =====
// Shared types, constants and register codes of the script tokenizer.
`timescale 1ns / 1ps

package stok_pkg;

    // Field widths.
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 10;
    localparam int CAP_W  = 11;

    // Token buffer capacity limits.
    localparam int MAX_TOKEN_BYTES = 1024;
    localparam int CAP_MAX         = (MAX_TOKEN_BYTES < 1024) ? MAX_TOKEN_BYTES : 1024;

    // Result bundle and queue sizing.
    localparam int MAX_RESULTS = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration port.
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [2:0] REG_COMMA_NOT_TOKEN        = 3'd0;
    localparam logic [2:0] REG_SINGLE_QUOTE_NOT_TOKEN = 3'd1;
    localparam logic [2:0] REG_BRACKETS_NOT_TOKEN     = 3'd2;
    localparam logic [2:0] REG_COLON_IS_TOKEN         = 3'd3;
    localparam logic [2:0] REG_NEWLINE_IS_TOKEN       = 3'd4;
    localparam logic [2:0] REG_HASH_STARTS_COMMENT    = 3'd5;
    localparam logic [2:0] REG_QUOTES_NOT_SPECIAL     = 3'd6;
    localparam logic [2:0] REG_TOKEN_CAPACITY         = 3'd7;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);

    // Scanner modes.
    localparam logic [2:0] MODE_SKIP    = 3'd0;
    localparam logic [2:0] MODE_SLASH   = 3'd1;
    localparam logic [2:0] MODE_COMMENT = 3'd2;
    localparam logic [2:0] MODE_WORD    = 3'd3;
    localparam logic [2:0] MODE_QUOTE   = 3'd4;
    localparam logic [2:0] MODE_QESC    = 3'd5;

    // Characters.
    localparam logic [BYTE_W-1:0] CH_NL     = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [BYTE_W-1:0] CH_DQUOTE = 8'h22;
    localparam logic [BYTE_W-1:0] CH_HASH   = 8'h23;
    localparam logic [BYTE_W-1:0] CH_APOS   = 8'h27;
    localparam logic [BYTE_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [BYTE_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_COLON  = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_LBRACE = 8'h7B;
    localparam logic [BYTE_W-1:0] CH_RBRACE = 8'h7D;

    typedef struct packed {
        logic             comma_not_token;
        logic             single_quote_not_token;
        logic             brackets_not_token;
        logic             colon_is_token;
        logic             newline_is_token;
        logic             hash_starts_comment;
        logic             quotes_not_special;
        logic [CAP_W-1:0] token_capacity;
    } cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              byte_valid;
        logic              token_end;
        logic [LEN_W-1:0]  token_length;
        logic              token_quoted;
        logic              token_overflow;
        logic              stream_end;
        logic              run_last;
    } result_t;

    typedef struct packed {
        logic [1:0]                    count;
        result_t [MAX_RESULTS-1:0]     res;
    } bundle_t;

    typedef struct packed {
        logic [2:0]                mode;
        logic [LEN_W-1:0]          klen;
        logic                      drop;
        logic [1:0]                n;
        result_t [MAX_RESULTS-1:0] res;
    } scan_t;

endpackage

// ===== src/stok_in_if.sv =====
// Input byte channel of the script tokenizer.
`timescale 1ns / 1ps

interface stok_in_if;
    logic                          valid;
    logic                          ready;
    logic [stok_pkg::BYTE_W-1:0]   in_byte;
    logic                          input_end;

    modport source (output valid, output in_byte, output input_end, input ready);
    modport sink   (input valid, input in_byte, input input_end, output ready);
endinterface

// ===== src/stok_out_if.sv =====
// Result channel of the script tokenizer.
`timescale 1ns / 1ps

interface stok_out_if;
    logic                          valid;
    logic                          ready;
    logic [stok_pkg::BYTE_W-1:0]   out_byte;
    logic                          byte_valid;
    logic                          token_end;
    logic [stok_pkg::LEN_W-1:0]    token_length;
    logic                          token_quoted;
    logic                          token_overflow;
    logic                          stream_end;
    logic                          run_last;

    modport source (
        output valid, output out_byte, output byte_valid, output token_end,
        output token_length, output token_quoted, output token_overflow,
        output stream_end, output run_last, input ready
    );
    modport sink (
        input valid, input out_byte, input byte_valid, input token_end,
        input token_length, input token_quoted, input token_overflow,
        input stream_end, input run_last, output ready
    );
endinterface

// ===== src/script_tokenizer.sv =====
// Top level of the script tokenizer: configuration registers and the three stages.
`timescale 1ns / 1ps

// Usage
//   in_ch carries one text byte per transfer with an input_end flag; a zero byte or
//   input_end closes the text, and the next byte starts a new one. out_ch carries one
//   result per transfer: a token byte, a token end marker with length, quoted and
//   overflow flags, or a lone end-of-text marker. run_last flags the last result
//   caused by one input byte; a byte may cause none (whitespace, comments) or up to 3.
//   Configuration is written over the APB-style port, register i at byte address 4*i;
//   the user must write it only while no results are pending; the block does not enforce this.
// Timing
//   The front end takes a byte every cycle while its 4-entry bundle queue has room;
//   the scanner mode and kept length update in that same cycle. With the queue empty,
//   the first result of a byte passes through a queue slot and then the output register
//   before it is valid at out_ch. The back end sends one result per cycle while out_ch
//   is ready, so the results of one byte leave one after another.
// Reset
//   rst_n clears the scanner to whitespace skipping, empties the queue and the output
//   register, and restores every register to its default (capacity 1024).
// Stall
//   When out_ch is not ready the output register holds; the queue fills and then
//   in_ch ready drops until space frees up. No result is lost or repeated.

module script_tokenizer (
    input  logic                          clk,
    input  logic                          rst_n,
    stok_in_if.sink                       in_ch,
    stok_out_if.source                    out_ch,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [stok_pkg::ADDR_W-1:0]   paddr,
    input  logic [stok_pkg::DATA_W-1:0]   pwdata,
    output logic [stok_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import stok_pkg::*;

    cfg_t       cfg_reg, cfg_next;
    logic       cfg_wr;
    logic [2:0] reg_idx;

    logic    q_push;
    logic    q_pop;
    logic    q_full;
    logic    q_empty;
    bundle_t q_in;
    bundle_t q_head;

    // Configuration port: always ready, write in the access phase.
    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            case (reg_idx)
                REG_COMMA_NOT_TOKEN:        cfg_next.comma_not_token        = pwdata[0];
                REG_SINGLE_QUOTE_NOT_TOKEN: cfg_next.single_quote_not_token = pwdata[0];
                REG_BRACKETS_NOT_TOKEN:     cfg_next.brackets_not_token     = pwdata[0];
                REG_COLON_IS_TOKEN:         cfg_next.colon_is_token         = pwdata[0];
                REG_NEWLINE_IS_TOKEN:       cfg_next.newline_is_token       = pwdata[0];
                REG_HASH_STARTS_COMMENT:    cfg_next.hash_starts_comment    = pwdata[0];
                REG_QUOTES_NOT_SPECIAL:     cfg_next.quotes_not_special     = pwdata[0];
                REG_TOKEN_CAPACITY:         cfg_next.token_capacity         = pwdata[CAP_W-1:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_COMMA_NOT_TOKEN:        prdata = DATA_W'(cfg_reg.comma_not_token);
            REG_SINGLE_QUOTE_NOT_TOKEN: prdata = DATA_W'(cfg_reg.single_quote_not_token);
            REG_BRACKETS_NOT_TOKEN:     prdata = DATA_W'(cfg_reg.brackets_not_token);
            REG_COLON_IS_TOKEN:         prdata = DATA_W'(cfg_reg.colon_is_token);
            REG_NEWLINE_IS_TOKEN:       prdata = DATA_W'(cfg_reg.newline_is_token);
            REG_HASH_STARTS_COMMENT:    prdata = DATA_W'(cfg_reg.hash_starts_comment);
            REG_QUOTES_NOT_SPECIAL:     prdata = DATA_W'(cfg_reg.quotes_not_special);
            REG_TOKEN_CAPACITY:         prdata = DATA_W'(cfg_reg.token_capacity);
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // Flags clear, capacity at its default.
            cfg_reg <= cfg_t'({7'b0, CAP_RESET});
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Scan each byte and hand its results over as one bundle.
    stok_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .cfg    (cfg_reg),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_in)
    );

    // Decouple scanning from result delivery.
    stok_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty),
        .full      (q_full)
    );

    // Send results one transfer at a time.
    stok_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (q_head),
        .empty  (q_empty),
        .pop    (q_pop),
        .out_ch (out_ch)
    );

    // The front end never writes into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
        else $error("bundle pushed into full queue");

    // The back end never pops an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_empty)
        else $error("bundle popped from empty queue");

    // Queued bundles always hold at least one result.
    assert property (@(posedge clk) disable iff (!rst_n) !q_empty |-> q_head.count != 2'd0)
        else $error("empty bundle in queue");

    // Token summary fields only ride on a token end.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.token_end) |->
        (out_ch.token_length == '0 && !out_ch.token_quoted && !out_ch.token_overflow))
        else $error("token summary without token end");

endmodule

// ===== src/stok_front.sv =====
// Front end: accepts text bytes, advances the scanner and builds result bundles.
`timescale 1ns / 1ps

module stok_front (
    input  logic              clk,
    input  logic              rst_n,
    stok_in_if.sink           in_ch,
    input  stok_pkg::cfg_t    cfg,
    input  logic              q_full,
    output logic              q_push,
    output stok_pkg::bundle_t q_data
);
    import stok_pkg::*;

    logic [2:0]       mode_reg, mode_next;
    logic [LEN_W-1:0] klen_reg, klen_next;
    logic             drop_reg, drop_next;
    logic [CAP_W-1:0] cap_eff;
    logic [LEN_W-1:0] limit;
    logic             accept;
    scan_t            s;

    function automatic scan_t put_res(scan_t st, logic [BYTE_W-1:0] b, logic bv, logic te,
                                      logic [LEN_W-1:0] len, logic q, logic ov, logic se);
        result_t r;
        r.out_byte       = b;
        r.byte_valid     = bv;
        r.token_end      = te;
        r.token_length   = len;
        r.token_quoted   = q;
        r.token_overflow = ov;
        r.stream_end     = se;
        r.run_last       = 1'b0;
        if (st.n != 2'(MAX_RESULTS))
        begin
            st.res[st.n] = r;
            st.n         = st.n + 2'd1;
        end
        return st;
    endfunction

    function automatic scan_t keep_byte(scan_t st, logic [BYTE_W-1:0] b, logic [LEN_W-1:0] lim);
        if (st.klen < lim)
        begin
            st      = put_res(st, b, 1'b1, 1'b0, '0, 1'b0, 1'b0, 1'b0);
            st.klen = st.klen + LEN_W'(1);
        end
        else
        begin
            st.drop = 1'b1;
        end
        return st;
    endfunction

    function automatic logic is_tok(logic [BYTE_W-1:0] b, cfg_t c);
        logic t;
        case (b)
            CH_LBRACE, CH_RBRACE: t = 1'b1;
            CH_COMMA:             t = !c.comma_not_token;
            CH_APOS:              t = !c.single_quote_not_token;
            CH_LPAREN, CH_RPAREN: t = !c.brackets_not_token;
            CH_COLON:             t = c.colon_is_token;
            CH_NL:                t = c.newline_is_token;
            default:              t = 1'b0;
        endcase
        return t;
    endfunction

    function automatic scan_t start_token(scan_t st, logic [2:0] m);
        st.klen = '0;
        st.drop = 1'b0;
        st.mode = m;
        return st;
    endfunction

    function automatic scan_t close_token(scan_t st, logic q, logic se);
        st      = put_res(st, '0, 1'b0, 1'b1, st.klen, q, st.drop, se);
        st.mode = MODE_SKIP;
        return st;
    endfunction

    function automatic scan_t skip_byte(scan_t st, logic [BYTE_W-1:0] b, cfg_t c,
                                        logic [LEN_W-1:0] lim);
        if (b <= CH_SPACE && !(c.newline_is_token && b == CH_NL))
        begin
            st = st;
        end
        else if (b == CH_SLASH)
        begin
            st.mode = MODE_SLASH;
        end
        else if (b == CH_HASH && c.hash_starts_comment)
        begin
            st.mode = MODE_COMMENT;
        end
        else if (b == CH_DQUOTE && !c.quotes_not_special)
        begin
            st = start_token(st, MODE_QUOTE);
        end
        else if (is_tok(b, c))
        begin
            st = put_res(st, b, 1'b1, 1'b1, LEN_W'(1), 1'b0, 1'b0, 1'b0);
        end
        else
        begin
            st = start_token(st, MODE_WORD);
            st = keep_byte(st, b, lim);
        end
        return st;
    endfunction

    function automatic scan_t word_byte(scan_t st, logic [BYTE_W-1:0] b, cfg_t c,
                                        logic [LEN_W-1:0] lim);
        if (b <= CH_SPACE || is_tok(b, c))
        begin
            st = close_token(st, 1'b0, 1'b0);
            st = skip_byte(st, b, c, lim);
        end
        else
        begin
            st = keep_byte(st, b, lim);
        end
        return st;
    endfunction

    function automatic scan_t quote_byte(scan_t st, logic [BYTE_W-1:0] b, logic [LEN_W-1:0] lim);
        if (b == CH_BSLASH)
        begin
            st.mode = MODE_QESC;
        end
        else if (b == CH_DQUOTE)
        begin
            st = close_token(st, 1'b1, 1'b0);
        end
        else
        begin
            st = keep_byte(st, b, lim);
        end
        return st;
    endfunction

    function automatic scan_t process_byte(scan_t st, logic [BYTE_W-1:0] b, cfg_t c,
                                           logic [LEN_W-1:0] lim);
        case (st.mode)
            MODE_SKIP:
            begin
                st = skip_byte(st, b, c, lim);
            end
            MODE_SLASH:
            begin
                if (b == CH_SLASH)
                begin
                    st.mode = MODE_COMMENT;
                end
                else
                begin
                    st = start_token(st, MODE_WORD);
                    st = keep_byte(st, CH_SLASH, lim);
                    st = word_byte(st, b, c, lim);
                end
            end
            MODE_COMMENT:
            begin
                if (b == CH_NL)
                begin
                    st.mode = MODE_SKIP;
                    st      = skip_byte(st, b, c, lim);
                end
            end
            MODE_WORD:
            begin
                st = word_byte(st, b, c, lim);
            end
            MODE_QUOTE:
            begin
                st = quote_byte(st, b, lim);
            end
            MODE_QESC:
            begin
                st.mode = MODE_QUOTE;
                if (b == CH_DQUOTE)
                begin
                    st = keep_byte(st, CH_DQUOTE, lim);
                end
                else
                begin
                    st = keep_byte(st, CH_BSLASH, lim);
                    st = quote_byte(st, b, lim);
                end
            end
            default:
            begin
                st.mode = MODE_SKIP;
                st      = skip_byte(st, b, c, lim);
            end
        endcase
        return st;
    endfunction

    function automatic scan_t finish_text(scan_t st, logic [LEN_W-1:0] lim);
        case (st.mode)
            MODE_SLASH:
            begin
                st = start_token(st, MODE_WORD);
                st = keep_byte(st, CH_SLASH, lim);
                st = close_token(st, 1'b0, 1'b1);
            end
            MODE_WORD:
            begin
                st = close_token(st, 1'b0, 1'b1);
            end
            MODE_QUOTE:
            begin
                st = close_token(st, 1'b1, 1'b1);
            end
            MODE_QESC:
            begin
                st = keep_byte(st, CH_BSLASH, lim);
                st = close_token(st, 1'b1, 1'b1);
            end
            default:
            begin
                // Mark the last token end of this byte, or add a lone end marker.
                if (st.n != 2'd0 && st.res[st.n - 2'd1].token_end)
                begin
                    st.res[st.n - 2'd1].stream_end = 1'b1;
                end
                else
                begin
                    st = put_res(st, '0, 1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b1);
                end
            end
        endcase
        st.mode = MODE_SKIP;
        st.klen = '0;
        st.drop = 1'b0;
        return st;
    endfunction

    // Clamp the capacity and keep at most capacity-1 bytes.
    always_comb
    begin
        if (cfg.token_capacity < CAP_W'(2))
        begin
            cap_eff = CAP_W'(2);
        end
        else if (cfg.token_capacity > CAP_W'(CAP_MAX))
        begin
            cap_eff = CAP_W'(CAP_MAX);
        end
        else
        begin
            cap_eff = cfg.token_capacity;
        end
        limit = LEN_W'(cap_eff - CAP_W'(1));
    end

    always_comb
    begin
        s      = '0;
        s.mode = mode_reg;
        s.klen = klen_reg;
        s.drop = drop_reg;
        if (in_ch.in_byte != '0)
        begin
            s = process_byte(s, in_ch.in_byte, cfg, limit);
        end
        if (in_ch.in_byte == '0 || in_ch.input_end)
        begin
            s = finish_text(s, limit);
        end
        if (s.n != 2'd0)
        begin
            s.res[s.n - 2'd1].run_last = 1'b1;
        end
    end

    assign in_ch.ready = !q_full;
    assign accept      = in_ch.valid && !q_full;
    assign q_push      = accept && (s.n != 2'd0);
    assign q_data.count = s.n;
    assign q_data.res   = s.res;

    always_comb
    begin
        mode_next = mode_reg;
        klen_next = klen_reg;
        drop_next = drop_reg;
        if (accept)
        begin
            mode_next = s.mode;
            klen_next = s.klen;
            drop_next = s.drop;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_SKIP;
            klen_reg <= '0;
            drop_reg <= 1'b0;
        end
        else
        begin
            mode_reg <= mode_next;
            klen_reg <= klen_next;
            drop_reg <= drop_next;
        end
    end

endmodule

// ===== src/stok_queue.sv =====
// Short bundle queue between the front end and the result sequencer.
`timescale 1ns / 1ps

module stok_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  stok_pkg::bundle_t push_data,
    input  logic              pop,
    output stok_pkg::bundle_t head,
    output logic              empty,
    output logic              full
);
    import stok_pkg::*;

    bundle_t           slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== src/stok_back.sv =====
// Back end: unpacks queued bundles into single results behind an output register.
`timescale 1ns / 1ps

module stok_back (
    input  logic              clk,
    input  logic              rst_n,
    input  stok_pkg::bundle_t head,
    input  logic              empty,
    output logic              pop,
    stok_out_if.source        out_ch
);
    import stok_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    result_t    out_data_reg;
    logic       load;

    assign load = !empty && (!out_valid_reg || out_ch.ready);
    assign pop  = load && (idx_reg == head.count - 2'd1);

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            idx_next       = pop ? 2'd0 : idx_reg + 2'd1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg <= head.res[idx_reg];
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.out_byte       = out_data_reg.out_byte;
    assign out_ch.byte_valid     = out_data_reg.byte_valid;
    assign out_ch.token_end      = out_data_reg.token_end;
    assign out_ch.token_length   = out_data_reg.token_length;
    assign out_ch.token_quoted   = out_data_reg.token_quoted;
    assign out_ch.token_overflow = out_data_reg.token_overflow;
    assign out_ch.stream_end     = out_data_reg.stream_end;
    assign out_ch.run_last       = out_data_reg.run_last;

endmodule

// ===== dv/stok_checker.sv =====
// Result checker of the script tokenizer: tracks registers, predicts tokens, compares.
`timescale 1ns / 1ps

module stok_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    stok_in_if                          in_mon,
    stok_out_if                         out_mon,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [stok_pkg::ADDR_W-1:0] paddr,
    input  logic [stok_pkg::DATA_W-1:0] pwdata,
    output int                          error_count,
    output int                          results_owed
);
    import stok_pkg::*;

    cfg_t             regs;
    logic [2:0]       mode;
    logic [LEN_W-1:0] kept;
    logic             dropped;
    result_t          step_results[$];
    result_t          owed_results[$];

    function automatic int usable_capacity();
        int c;
        c = int'(regs.token_capacity);
        if (c < 2)
        begin
            c = 2;
        end
        if (c > CAP_MAX)
        begin
            c = CAP_MAX;
        end
        return c;
    endfunction

    function automatic logic is_single(input logic [BYTE_W-1:0] b);
        case (b)
            CH_LBRACE, CH_RBRACE: return 1'b1;
            CH_COMMA:             return !regs.comma_not_token;
            CH_APOS:              return !regs.single_quote_not_token;
            CH_LPAREN, CH_RPAREN: return !regs.brackets_not_token;
            CH_COLON:             return regs.colon_is_token;
            CH_NL:                return regs.newline_is_token;
            default:              return 1'b0;
        endcase
    endfunction

    task automatic emit(input logic [BYTE_W-1:0] b, input logic bv, input logic te,
                        input logic [LEN_W-1:0] len, input logic q, input logic ov,
                        input logic se);
        result_t r;
        if (step_results.size() < MAX_RESULTS)
        begin
            r.out_byte       = b;
            r.byte_valid     = bv;
            r.token_end      = te;
            r.token_length   = len;
            r.token_quoted   = q;
            r.token_overflow = ov;
            r.stream_end     = se;
            r.run_last       = 1'b0;
            step_results.push_back(r);
        end
    endtask

    // Keep a token byte, or mark the token as truncated once the buffer is full.
    task automatic keep(input logic [BYTE_W-1:0] b);
        if (int'(kept) + 1 < usable_capacity())
        begin
            emit(b, 1'b1, 1'b0, '0, 1'b0, 1'b0, 1'b0);
            kept = kept + LEN_W'(1);
        end
        else
        begin
            dropped = 1'b1;
        end
    endtask

    task automatic open_token(input logic [2:0] m);
        kept    = '0;
        dropped = 1'b0;
        mode    = m;
    endtask

    task automatic close_token(input logic q, input logic se);
        emit('0, 1'b0, 1'b1, kept, q, dropped, se);
        mode = MODE_SKIP;
    endtask

    task automatic skip_char(input logic [BYTE_W-1:0] b);
        if (b <= CH_SPACE && !(regs.newline_is_token && b == CH_NL))
        begin
            return;
        end
        if (b == CH_SLASH)
        begin
            mode = MODE_SLASH;
        end
        else if (b == CH_HASH && regs.hash_starts_comment)
        begin
            mode = MODE_COMMENT;
        end
        else if (b == CH_DQUOTE && !regs.quotes_not_special)
        begin
            open_token(MODE_QUOTE);
        end
        else if (is_single(b))
        begin
            emit(b, 1'b1, 1'b1, LEN_W'(1), 1'b0, 1'b0, 1'b0);
        end
        else
        begin
            open_token(MODE_WORD);
            keep(b);
        end
    endtask

    // A delimiter closes the word and is then scanned as a fresh byte.
    task automatic word_char(input logic [BYTE_W-1:0] b);
        if (b <= CH_SPACE || is_single(b))
        begin
            close_token(1'b0, 1'b0);
            skip_char(b);
        end
        else
        begin
            keep(b);
        end
    endtask

    task automatic quote_char(input logic [BYTE_W-1:0] b);
        if (b == CH_BSLASH)
        begin
            mode = MODE_QESC;
        end
        else if (b == CH_DQUOTE)
        begin
            close_token(1'b1, 1'b0);
        end
        else
        begin
            keep(b);
        end
    endtask

    task automatic scan_char(input logic [BYTE_W-1:0] b);
        case (mode)
            MODE_SKIP: skip_char(b);
            MODE_SLASH:
            begin
                if (b == CH_SLASH)
                begin
                    mode = MODE_COMMENT;
                end
                else
                begin
                    open_token(MODE_WORD);
                    keep(CH_SLASH);
                    word_char(b);
                end
            end
            MODE_COMMENT:
            begin
                if (b == CH_NL)
                begin
                    mode = MODE_SKIP;
                    skip_char(b);
                end
            end
            MODE_WORD:  word_char(b);
            MODE_QUOTE: quote_char(b);
            MODE_QESC:
            begin
                mode = MODE_QUOTE;
                if (b == CH_DQUOTE)
                begin
                    keep(CH_DQUOTE);
                end
                else
                begin
                    keep(CH_BSLASH);
                    quote_char(b);
                end
            end
            default:
            begin
                mode = MODE_SKIP;
                skip_char(b);
            end
        endcase
    endtask

    // Close whatever is open and flag the end of text on the last result.
    task automatic end_text();
        result_t r;
        case (mode)
            MODE_SLASH:
            begin
                open_token(MODE_WORD);
                keep(CH_SLASH);
                close_token(1'b0, 1'b1);
            end
            MODE_WORD:  close_token(1'b0, 1'b1);
            MODE_QUOTE: close_token(1'b1, 1'b1);
            MODE_QESC:
            begin
                keep(CH_BSLASH);
                close_token(1'b1, 1'b1);
            end
            default:
            begin
                if (step_results.size() > 0 && step_results[$].token_end)
                begin
                    r = step_results.pop_back();
                    r.stream_end = 1'b1;
                    step_results.push_back(r);
                end
                else
                begin
                    emit('0, 1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b1);
                end
            end
        endcase
        mode    = MODE_SKIP;
        kept    = '0;
        dropped = 1'b0;
    endtask

    task automatic tokenize_byte(input logic [BYTE_W-1:0] b, input logic last);
        result_t r;
        step_results.delete();
        if (b != '0)
        begin
            scan_char(b);
        end
        if (b == '0 || last)
        begin
            end_text();
        end
        if (step_results.size() > 0)
        begin
            r = step_results.pop_back();
            r.run_last = 1'b1;
            step_results.push_back(r);
        end
        foreach (step_results[i])
        begin
            owed_results.push_back(step_results[i]);
        end
    endtask

    task automatic flag_field(input string name, input int want, input int got);
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
        error_count++;
    endtask

    task automatic check_result(input result_t got);
        result_t want;
        if (owed_results.size() == 0)
        begin
            $display("%0t: unexpected result: expected none, got byte %0d bv %b end %b len %0d",
                     $time, got.out_byte, got.byte_valid, got.token_end, got.token_length);
            error_count++;
            return;
        end
        want = owed_results.pop_front();
        if (got.out_byte !== want.out_byte)
            flag_field("out_byte", want.out_byte, got.out_byte);
        if (got.byte_valid !== want.byte_valid)
            flag_field("byte_valid", want.byte_valid, got.byte_valid);
        if (got.token_end !== want.token_end)
            flag_field("token_end", want.token_end, got.token_end);
        if (got.token_length !== want.token_length)
            flag_field("token_length", want.token_length, got.token_length);
        if (got.token_quoted !== want.token_quoted)
            flag_field("token_quoted", want.token_quoted, got.token_quoted);
        if (got.token_overflow !== want.token_overflow)
            flag_field("token_overflow", want.token_overflow, got.token_overflow);
        if (got.stream_end !== want.stream_end)
            flag_field("stream_end", want.stream_end, got.stream_end);
        if (got.run_last !== want.run_last)
            flag_field("run_last", want.run_last, got.run_last);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs                = '0;
            regs.token_capacity = CAP_RESET;
            mode                = MODE_SKIP;
            kept                = '0;
            dropped             = 1'b0;
            owed_results.delete();
            error_count         = 0;
            results_owed        = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[ADDR_W-1:2])
                    REG_COMMA_NOT_TOKEN:        regs.comma_not_token        = pwdata[0];
                    REG_SINGLE_QUOTE_NOT_TOKEN: regs.single_quote_not_token = pwdata[0];
                    REG_BRACKETS_NOT_TOKEN:     regs.brackets_not_token     = pwdata[0];
                    REG_COLON_IS_TOKEN:         regs.colon_is_token         = pwdata[0];
                    REG_NEWLINE_IS_TOKEN:       regs.newline_is_token       = pwdata[0];
                    REG_HASH_STARTS_COMMENT:    regs.hash_starts_comment    = pwdata[0];
                    REG_QUOTES_NOT_SPECIAL:     regs.quotes_not_special     = pwdata[0];
                    REG_TOKEN_CAPACITY:         regs.token_capacity = pwdata[CAP_W-1:0];
                    default: ;
                endcase
            end
            if (in_mon.valid && in_mon.ready)
            begin
                tokenize_byte(in_mon.in_byte, in_mon.input_end);
            end
            if (out_mon.valid && out_mon.ready)
            begin
                check_result({out_mon.out_byte, out_mon.byte_valid, out_mon.token_end,
                              out_mon.token_length, out_mon.token_quoted,
                              out_mon.token_overflow, out_mon.stream_end,
                              out_mon.run_last});
            end
            results_owed = owed_results.size();
        end
    end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top of the script tokenizer: clock, reset, text stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
    import stok_pkg::*;

    // Whole-run guard; the slowest legal run stays far below this.
    localparam int TIMEOUT_NS   = 4_000_000;
    // Cycles to let trailing result-free bytes leave the pipeline.
    localparam int SETTLE_CYCLES = 16;
    // Random bytes per configuration phase, and number of phases.
    localparam int PHASE_BYTES  = 16;
    localparam int PHASES       = 7;
    // Buffer for the long word, and one word longer than it, to saturate the length.
    localparam int LONG_CAP     = 64;
    localparam int LONG_WORD    = LONG_CAP + 6;
    localparam logic [BYTE_W-1:0] PUNCT [8] = '{CH_LBRACE, CH_RBRACE, CH_COMMA, CH_APOS,
                                                 CH_LPAREN, CH_RPAREN, CH_COLON, CH_NL};

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    int                error_count;
    int                results_owed;
    int                sent;
    bit                quiet;

    stok_in_if  in_ch ();
    stok_out_if out_ch ();

    script_tokenizer dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    stok_checker chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_mon       (in_ch),
        .out_mon      (out_ch),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .error_count  (error_count),
        .results_owed (results_owed)
    );

    // 20 ns period.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Result side: drop ready about 30 percent of the time, never during a quiet stretch.
    always @(negedge clk)
    begin
        out_ch.ready <= quiet || ($urandom_range(99) >= 30);
    end

    // Guard against a hung handshake.
    initial
    begin
        #(TIMEOUT_NS);
        $display("Verification failed");
        $finish;
    end

    // Offer one byte and hold it until the transfer happens. Called at a falling edge;
    // returns at the falling edge after the transfer without touching valid, so the
    // next byte can follow back to back.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
        if (!quiet)
        begin
            while ($urandom_range(99) < 30)
            begin
                in_ch.valid <= 1'b0;
                @(negedge clk);
            end
        end
        in_ch.valid     <= 1'b1;
        in_ch.in_byte   <= b;
        in_ch.input_end <= last;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        sent++;
    endtask

    task automatic send_text(input string s, input logic end_on_last);
        for (int i = 0; i < s.len(); i++)
        begin
            send_byte(s[i], end_on_last && (i == s.len() - 1));
        end
    endtask

    // Drop valid and hold off until every owed result has been taken, then let any
    // result-free bytes still in flight drain out.
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (results_owed != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Setup cycle, then access cycle; the register takes the value at the access edge.
    task automatic apb_write(input logic [2:0] idx, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic write_regs(input cfg_t c);
        apb_write(REG_COMMA_NOT_TOKEN,        DATA_W'(c.comma_not_token));
        apb_write(REG_SINGLE_QUOTE_NOT_TOKEN, DATA_W'(c.single_quote_not_token));
        apb_write(REG_BRACKETS_NOT_TOKEN,     DATA_W'(c.brackets_not_token));
        apb_write(REG_COLON_IS_TOKEN,         DATA_W'(c.colon_is_token));
        apb_write(REG_NEWLINE_IS_TOKEN,       DATA_W'(c.newline_is_token));
        apb_write(REG_HASH_STARTS_COMMENT,    DATA_W'(c.hash_starts_comment));
        apb_write(REG_QUOTES_NOT_SPECIAL,     DATA_W'(c.quotes_not_special));
        apb_write(REG_TOKEN_CAPACITY,         DATA_W'(c.token_capacity));
    endtask

    // Mostly lowercase letters, sometimes any printable or high byte.
    function automatic logic [BYTE_W-1:0] word_char();
        if ($urandom_range(4) != 0)
            return BYTE_W'($urandom_range(8'h61, 8'h7A));
        return BYTE_W'($urandom_range(8'h21, 8'hFF));
    endfunction

    // Any nonzero byte except the two given.
    function automatic logic [BYTE_W-1:0] other_byte(input logic [BYTE_W-1:0] ex_a,
                                                     input logic [BYTE_W-1:0] ex_b);
        logic [BYTE_W-1:0] pick;
        do
            pick = BYTE_W'($urandom_range(1, 255));
        while (pick == ex_a || pick == ex_b);
        return pick;
    endfunction

    // Build one well-formed piece of text with random content (or a noise byte) and
    // send it; occasionally the last byte closes the text.
    task automatic send_lexeme(input int word_max);
        logic [BYTE_W-1:0] lex[$];
        int                kind;
        int                len;
        kind = $urandom_range(99);
        len  = $urandom_range(1, word_max);
        if (kind < 12)
        begin
            lex.push_back(BYTE_W'($urandom));
        end
        else if (kind < 32)
        begin
            repeat (len) lex.push_back(word_char());
        end
        else if (kind < 44)
        begin
            // Quoted string with escapes; sometimes left open.
            lex.push_back(CH_DQUOTE);
            repeat (len)
            begin
                if ($urandom_range(5) == 0)
                begin
                    lex.push_back(CH_BSLASH);
                    lex.push_back($urandom_range(1) ? CH_DQUOTE : word_char());
                end
                else
                begin
                    lex.push_back(other_byte(CH_DQUOTE, CH_BSLASH));
                end
            end
            if ($urandom_range(9) != 0)
                lex.push_back(CH_DQUOTE);
        end
        else if (kind < 54)
        begin
            // Line comment, slash-slash or hash.
            if ($urandom_range(1))
            begin
                lex.push_back(CH_HASH);
            end
            else
            begin
                lex.push_back(CH_SLASH);
                lex.push_back(CH_SLASH);
            end
            repeat (len) lex.push_back(other_byte(CH_NL, CH_NL));
            lex.push_back(CH_NL);
        end
        else if (kind < 72)
        begin
            lex.push_back(PUNCT[$urandom_range(7)]);
        end
        else if (kind < 90)
        begin
            repeat ($urandom_range(1, 3)) lex.push_back(BYTE_W'($urandom_range(1, 32)));
        end
        else if (kind < 94)
        begin
            lex.push_back('0);
        end
        else
        begin
            lex.push_back(CH_SLASH);
        end
        foreach (lex[i])
        begin
            send_byte(lex[i], (i == lex.size() - 1) && ($urandom_range(19) == 0));
        end
    endtask

    initial
    begin
        cfg_t c;
        int   target;
        int   word_max;

        // Drive every input to a known value before reset is released.
        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        in_ch.valid     = 1'b0;
        in_ch.in_byte   = '0;
        in_ch.input_end = 1'b0;
        quiet           = 1'b0;
        sent            = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed text at default settings: every one-byte token, a word with a colon,
        // an escaped quote, a comment, then a lone slash that ends the text.
        c                = '0;
        c.token_capacity = CAP_RESET;
        write_regs(c);
        send_text("{}(),'a:b \"x\\\"y\" //c\n/", 1'b1);
        // Unterminated quote with a backslash still pending at the end of text.
        send_text("\"q\\", 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        // Hold the sender until every owed result has come back.
        wait_idle();

        // Random phases, each under its own register settings.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            {c.comma_not_token, c.single_quote_not_token, c.brackets_not_token,
             c.colon_is_token, c.newline_is_token, c.hash_starts_comment,
             c.quotes_not_special} = 7'($urandom);
            c.token_capacity = CAP_W'($urandom_range(2, 10));
            if (ph == 0)
            begin
                // Every flag set, smallest buffer.
                {c.comma_not_token, c.single_quote_not_token, c.brackets_not_token,
                 c.colon_is_token, c.newline_is_token, c.hash_starts_comment,
                 c.quotes_not_special} = '1;
                c.token_capacity = CAP_W'(2);
            end
            else if (ph == 1)
            begin
                // Colon, newline and hash handling on, quotes active.
                c.colon_is_token     = 1'b1;
                c.newline_is_token   = 1'b1;
                c.hash_starts_comment = 1'b1;
                c.quotes_not_special = 1'b0;
                c.token_capacity     = CAP_W'(3);
            end
            else if (ph == PHASES - 1)
            begin
                c.token_capacity = CAP_W'(CAP_MAX);
            end
            write_regs(c);
            // Run one phase back to back on both sides.
            quiet    = (ph == 2);
            word_max = (c.token_capacity < 10) ? int'(c.token_capacity) + 2 : 12;
            target   = sent + PHASE_BYTES;
            while (sent < target)
            begin
                send_lexeme(word_max);
            end
            wait_idle();
        end

        // One word past a mid-size buffer: overflow, saturated length and end of text,
        // sent back to back on both sides.
        quiet            = 1'b1;
        c                = '0;
        c.token_capacity = CAP_W'(LONG_CAP);
        write_regs(c);
        for (int i = 0; i < LONG_WORD; i++)
        begin
            send_byte(8'h78, i == LONG_WORD - 1);
        end
        wait_idle();
        quiet = 1'b0;

        if (error_count == 0 && results_owed == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
